// File: rtl/core/per_key_bounded_queue_holder_assert.svh
// assertion macros shared by the queue holder rtl
// depends on nothing; included by the modules that check their own logic
`ifndef PER_KEY_BOUNDED_QUEUE_HOLDER_ASSERT_SVH
`define PER_KEY_BOUNDED_QUEUE_HOLDER_ASSERT_SVH

// condition in this cycle implies consequence in this cycle
`define BQH_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("bqh check failed");

// condition in this cycle implies consequence in the next cycle
`define BQH_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("bqh check failed");

`endif

// File: rtl/core/bqh_pkg.sv
// shared types and constants of the per-key bounded queue holder
// depends on nothing
package bqh_pkg;

   localparam int MaxCharactersDefault = 16;
   localparam int QueueDepthDefault    = 8;
   localparam logic [31:0] TtlReset    = 32'd900;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_EXPIRE = 2'd1,
      CMD_TAKE   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [31:0] stamp;
      logic        done;
      logic [31:0] payload;
   } cell_word_type;

   localparam int CellWidth = $bits(cell_word_type);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SC_RD, ST_SC_CHK, ST_SC_DONE, ST_OV_RD, ST_OV_CHK,
      ST_SH_RD, ST_SH_WR, ST_PU_APP, ST_PU_FIN, ST_EX_SLOT, ST_EX_FILL,
      ST_EX_HEAD, ST_EX_HCHK, ST_EX_END, ST_TK_RD, ST_TK_EMIT, ST_EMIT
   } state_type;

endpackage

// File: rtl/core/bqh_ram.sv
// simple dual port ram with registered read data, used for slot and cell stores
// depends on nothing
module bqh_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                      rd_data
);

   logic [Width-1:0] mem [Depth];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/bqh_ctrl.sv
// sequencer of the queue holder: slot scan, shift, expiry walk and take readout
// depends on bqh_pkg and per_key_bounded_queue_holder_assert.svh
`include "per_key_bounded_queue_holder_assert.svh"

module bqh_ctrl import bqh_pkg::*; #(
   parameter int MaxCharacters = MaxCharactersDefault,
   parameter int QueueDepth    = QueueDepthDefault,
   localparam int SW  = (MaxCharacters > 1) ? $clog2(MaxCharacters) : 1,
   localparam int FW  = $clog2(QueueDepth + 1),
   localparam int CAW = (MaxCharacters * QueueDepth > 1) ?
                        $clog2(MaxCharacters * QueueDepth) : 1,
   localparam int SLW = 32 + FW
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          ttl_ticks,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [31:0]          req_character_id,
   input  logic [31:0]          req_payload,
   input  logic                 req_completed,
   input  logic [31:0]          req_time_now,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_entry_valid,
   output logic [31:0]          rsp_entry_payload,
   output logic                 rsp_entry_completed,
   output logic [31:0]          rsp_entry_time,
   output logic                 rsp_last_of_run,
   output logic [7:0]           rsp_dropped_count,
   output logic                 rsp_evicted_count,
   output logic [7:0]           rsp_total_held,
   output logic                 slot_wr_en,
   output logic [SW-1:0]        slot_wr_addr,
   output logic [SLW-1:0]       slot_wr_data,
   output logic                 slot_rd_en,
   output logic [SW-1:0]        slot_rd_addr,
   input  logic [SLW-1:0]       slot_rd_data,
   output logic                 cell_wr_en,
   output logic [CAW-1:0]       cell_wr_addr,
   output cell_word_type        cell_wr_data,
   output logic                 cell_rd_en,
   output logic [CAW-1:0]       cell_rd_addr,
   input  cell_word_type        cell_rd_data
);

   localparam int TW  = $clog2(MaxCharacters * QueueDepth + 1);
   localparam int AW2 = CAW + FW + 1;

   // state and command registers
   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [31:0]      key_ff, key_in;
   logic [31:0]      pay_ff, pay_in;
   logic             done_ff, done_in;
   logic [31:0]      now_ff, now_in;
   // scan registers
   logic [SW-1:0]    sc_ff, sc_in;
   logic [CAW-1:0]   base_ff, base_in;
   logic             hit_ff, hit_in;
   logic [SW-1:0]    hit_slot_ff, hit_slot_in;
   logic [CAW-1:0]   hit_base_ff, hit_base_in;
   logic [FW-1:0]    hit_fill_ff, hit_fill_in;
   logic             vic_ff, vic_in;
   logic [SW-1:0]    vic_slot_ff, vic_slot_in;
   logic [CAW-1:0]   vic_base_ff, vic_base_in;
   logic [FW-1:0]    vic_fill_ff, vic_fill_in;
   logic [31:0]      best_ff, best_in;
   logic             free_ff, free_in;
   logic [SW-1:0]    free_slot_ff, free_slot_in;
   logic [CAW-1:0]   free_base_ff, free_base_in;
   // working registers
   logic [SW-1:0]    tslot_ff, tslot_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [31:0]      ckey_ff, ckey_in;
   logic [FW-1:0]    ix_ff, ix_in;
   logic [MaxCharacters-1:0] used_ff, used_in;
   logic [TW-1:0]    total_ff, total_in;
   logic [TW-1:0]    drop_ff, drop_in;
   logic             evict_ff, evict_in;
   // output register
   logic             ov_ff, ov_in;
   logic             oe_valid_ff, oe_valid_in;
   logic [31:0]      oe_pay_ff, oe_pay_in;
   logic             oe_done_ff, oe_done_in;
   logic [31:0]      oe_time_ff, oe_time_in;
   logic             olast_ff, olast_in;
   logic [TW-1:0]    odrop_ff, odrop_in;
   logic             oevict_ff, oevict_in;
   logic [TW-1:0]    ototal_ff, ototal_in;

   // shared age unit
   logic [31:0]      age;
   logic             age_gt_best;
   logic             age_ge_ttl;
   logic             out_free;
   logic             last_slot;
   logic [AW2-1:0]   addr_ix;
   logic [AW2-1:0]   addr_ix1;
   logic [AW2-1:0]   addr_fill;
   logic [FW:0]      ix_next;
   logic [31:0]      srd_key;
   logic [FW-1:0]    srd_fill;
   logic [TW+7:0]    drop_ext;
   logic [TW+7:0]    total_ext;

   assign age         = now_ff - cell_rd_data.stamp;
   assign age_gt_best = age > best_ff;
   assign age_ge_ttl  = age >= ttl_ticks;
   assign out_free    = !ov_ff || rsp_ready;
   assign last_slot   = (sc_ff == SW'(MaxCharacters - 1));
   assign addr_ix     = AW2'(base_ff) + AW2'(ix_ff);
   assign addr_ix1    = addr_ix + AW2'(1);
   assign addr_fill   = AW2'(base_ff) + AW2'(fill_ff);
   assign ix_next     = (FW + 1)'(ix_ff) + (FW + 1)'(1);
   assign srd_key     = slot_rd_data[SLW-1:FW];
   assign srd_fill    = slot_rd_data[FW-1:0];

   // next state and datapath control
   always_comb begin
      state_in = state_ff;  cmd_in = cmd_ff;  key_in = key_ff;  pay_in = pay_ff;
      done_in = done_ff;  now_in = now_ff;  sc_in = sc_ff;  base_in = base_ff;
      hit_in = hit_ff;  hit_slot_in = hit_slot_ff;  hit_base_in = hit_base_ff;
      hit_fill_in = hit_fill_ff;  vic_in = vic_ff;  vic_slot_in = vic_slot_ff;
      vic_base_in = vic_base_ff;  vic_fill_in = vic_fill_ff;  best_in = best_ff;
      free_in = free_ff;  free_slot_in = free_slot_ff;  free_base_in = free_base_ff;
      tslot_in = tslot_ff;  fill_in = fill_ff;  ckey_in = ckey_ff;  ix_in = ix_ff;
      used_in = used_ff;  total_in = total_ff;  drop_in = drop_ff;  evict_in = evict_ff;
      ov_in = ov_ff && !rsp_ready;
      oe_valid_in = oe_valid_ff;  oe_pay_in = oe_pay_ff;  oe_done_in = oe_done_ff;
      oe_time_in = oe_time_ff;  olast_in = olast_ff;  odrop_in = odrop_ff;
      oevict_in = oevict_ff;  ototal_in = ototal_ff;
      slot_wr_en = 1'b0;  slot_wr_addr = tslot_ff;  slot_wr_data = {key_ff, fill_ff};
      slot_rd_en = 1'b0;  slot_rd_addr = sc_ff;
      cell_wr_en = 1'b0;  cell_wr_addr = addr_ix[CAW-1:0];  cell_wr_data = cell_rd_data;
      cell_rd_en = 1'b0;  cell_rd_addr = addr_ix1[CAW-1:0];
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = cmd_type'(req_command);
               key_in = req_character_id;
               pay_in = req_payload;
               done_in = req_completed;
               now_in = req_time_now;
               sc_in = '0;
               base_in = '0;
               hit_in = 1'b0;
               vic_in = 1'b0;
               free_in = 1'b0;
               best_in = '0;
               drop_in = '0;
               evict_in = 1'b0;
               unique case (cmd_type'(req_command))
                  CMD_PUSH, CMD_TAKE: state_in = ST_SC_RD;
                  CMD_EXPIRE:         state_in = ST_EX_SLOT;
                  default:            state_in = ST_EMIT;
               endcase
            end
         end
         // scan: read slot entry and its head cell
         ST_SC_RD: begin
            slot_rd_en = 1'b1;
            cell_rd_en = 1'b1;
            cell_rd_addr = base_ff;
            state_in = ST_SC_CHK;
         end
         ST_SC_CHK: begin
            if (used_ff[sc_ff]) begin
               if (!hit_ff && srd_key == key_ff) begin
                  hit_in = 1'b1;
                  hit_slot_in = sc_ff;
                  hit_base_in = base_ff;
                  hit_fill_in = srd_fill;
               end
               if (!vic_ff || age_gt_best) begin
                  vic_in = 1'b1;
                  best_in = age;
                  vic_slot_in = sc_ff;
                  vic_base_in = base_ff;
                  vic_fill_in = srd_fill;
               end
            end else if (!free_ff) begin
               free_in = 1'b1;
               free_slot_in = sc_ff;
               free_base_in = base_ff;
            end
            if (last_slot) begin
               state_in = ST_SC_DONE;
            end else begin
               sc_in = sc_ff + SW'(1);
               base_in = base_ff + CAW'(QueueDepth);
               state_in = ST_SC_RD;
            end
         end
         ST_SC_DONE: begin
            ix_in = '0;
            if (cmd_ff == CMD_TAKE) begin
               if (!hit_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  used_in[hit_slot_ff] = 1'b0;
                  total_in = total_ff - TW'(hit_fill_ff);
                  fill_in = hit_fill_ff;
                  base_in = hit_base_ff;
                  state_in = ST_TK_RD;
               end
            end else begin
               if (hit_ff) begin
                  tslot_in = hit_slot_ff;
                  base_in = hit_base_ff;
                  fill_in = hit_fill_ff;
               end else if (free_ff) begin
                  tslot_in = free_slot_ff;
                  base_in = free_base_ff;
                  fill_in = '0;
                  used_in[free_slot_ff] = 1'b1;
               end else begin
                  evict_in = 1'b1;
                  total_in = total_ff - TW'(vic_fill_ff);
                  tslot_in = vic_slot_ff;
                  base_in = vic_base_ff;
                  fill_in = '0;
               end
               if (hit_ff && hit_fill_ff == FW'(QueueDepth)) begin
                  state_in = ST_OV_RD;
               end else begin
                  state_in = ST_PU_APP;
               end
            end
         end
         // overflow: look for the oldest non-completed entry
         ST_OV_RD: begin
            cell_rd_en = 1'b1;
            cell_rd_addr = addr_ix[CAW-1:0];
            state_in = ST_OV_CHK;
         end
         ST_OV_CHK: begin
            drop_in = TW'(1);
            if (!cell_rd_data.done) begin
               state_in = ST_SH_RD;
            end else if (ix_ff == fill_ff - FW'(1)) begin
               if (!done_ff) begin
                  state_in = ST_PU_FIN;
               end else begin
                  ix_in = '0;
                  state_in = ST_SH_RD;
               end
            end else begin
               ix_in = ix_next[FW-1:0];
               state_in = ST_OV_RD;
            end
         end
         // shift entries above ix down by one, then shrink the queue
         ST_SH_RD: begin
            if (ix_next < (FW + 1)'(fill_ff)) begin
               cell_rd_en = 1'b1;
               state_in = ST_SH_WR;
            end else begin
               fill_in = fill_ff - FW'(1);
               total_in = total_ff - TW'(1);
               state_in = (cmd_ff == CMD_EXPIRE) ? ST_EX_HEAD : ST_PU_APP;
            end
         end
         ST_SH_WR: begin
            cell_wr_en = 1'b1;
            ix_in = ix_next[FW-1:0];
            state_in = ST_SH_RD;
         end
         ST_PU_APP: begin
            cell_wr_en = 1'b1;
            cell_wr_addr = addr_fill[CAW-1:0];
            cell_wr_data = '{stamp: now_ff, done: done_ff, payload: pay_ff};
            fill_in = fill_ff + FW'(1);
            total_in = total_ff + TW'(1);
            state_in = ST_PU_FIN;
         end
         ST_PU_FIN: begin
            slot_wr_en = 1'b1;
            state_in = ST_EMIT;
         end
         // expiry walk over the slots
         ST_EX_SLOT: begin
            if (used_ff[sc_ff]) begin
               slot_rd_en = 1'b1;
               state_in = ST_EX_FILL;
            end else if (last_slot) begin
               state_in = ST_EMIT;
            end else begin
               sc_in = sc_ff + SW'(1);
               base_in = base_ff + CAW'(QueueDepth);
            end
         end
         ST_EX_FILL: begin
            fill_in = srd_fill;
            ckey_in = srd_key;
            state_in = ST_EX_HEAD;
         end
         ST_EX_HEAD: begin
            if (fill_ff == '0) begin
               state_in = ST_EX_END;
            end else begin
               cell_rd_en = 1'b1;
               cell_rd_addr = base_ff;
               state_in = ST_EX_HCHK;
            end
         end
         ST_EX_HCHK: begin
            if (age_ge_ttl) begin
               drop_in = drop_ff + TW'(1);
               ix_in = '0;
               state_in = ST_SH_RD;
            end else begin
               state_in = ST_EX_END;
            end
         end
         ST_EX_END: begin
            slot_wr_en = 1'b1;
            slot_wr_addr = sc_ff;
            slot_wr_data = {ckey_ff, fill_ff};
            if (fill_ff == '0) begin
               used_in[sc_ff] = 1'b0;
            end
            if (last_slot) begin
               state_in = ST_EMIT;
            end else begin
               sc_in = sc_ff + SW'(1);
               base_in = base_ff + CAW'(QueueDepth);
               state_in = ST_EX_SLOT;
            end
         end
         // take readout, one beat per entry
         ST_TK_RD: begin
            cell_rd_en = 1'b1;
            cell_rd_addr = addr_ix[CAW-1:0];
            state_in = ST_TK_EMIT;
         end
         ST_TK_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               oe_valid_in = 1'b1;
               oe_pay_in = cell_rd_data.payload;
               oe_done_in = cell_rd_data.done;
               oe_time_in = cell_rd_data.stamp;
               olast_in = (ix_ff == fill_ff - FW'(1));
               odrop_in = '0;
               oevict_in = 1'b0;
               ototal_in = total_ff;
               if (ix_ff == fill_ff - FW'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  ix_in = ix_next[FW-1:0];
                  state_in = ST_TK_RD;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               oe_valid_in = 1'b0;
               oe_pay_in = '0;
               oe_done_in = 1'b0;
               oe_time_in = '0;
               olast_in = 1'b1;
               odrop_in = drop_ff;
               oevict_in = evict_ff;
               ototal_in = total_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         total_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         total_ff <= total_in;
         ov_ff    <= ov_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  key_ff <= key_in;  pay_ff <= pay_in;  done_ff <= done_in;
      now_ff <= now_in;  sc_ff <= sc_in;  base_ff <= base_in;  hit_ff <= hit_in;
      hit_slot_ff <= hit_slot_in;  hit_base_ff <= hit_base_in;  hit_fill_ff <= hit_fill_in;
      vic_ff <= vic_in;  vic_slot_ff <= vic_slot_in;  vic_base_ff <= vic_base_in;
      vic_fill_ff <= vic_fill_in;  best_ff <= best_in;  free_ff <= free_in;
      free_slot_ff <= free_slot_in;  free_base_ff <= free_base_in;  tslot_ff <= tslot_in;
      fill_ff <= fill_in;  ckey_ff <= ckey_in;  ix_ff <= ix_in;  drop_ff <= drop_in;
      evict_ff <= evict_in;  oe_valid_ff <= oe_valid_in;  oe_pay_ff <= oe_pay_in;
      oe_done_ff <= oe_done_in;  oe_time_ff <= oe_time_in;  olast_ff <= olast_in;
      odrop_ff <= odrop_in;  oevict_ff <= oevict_in;  ototal_ff <= ototal_in;
   end

   // result port
   assign drop_ext            = {8'b0, odrop_ff};
   assign total_ext           = {8'b0, ototal_ff};
   assign rsp_valid           = ov_ff;
   assign rsp_entry_valid     = oe_valid_ff;
   assign rsp_entry_payload   = oe_pay_ff;
   assign rsp_entry_completed = oe_done_ff;
   assign rsp_entry_time      = oe_time_ff;
   assign rsp_last_of_run     = olast_ff;
   assign rsp_dropped_count   = drop_ext[7:0];
   assign rsp_evicted_count   = oevict_ff;
   assign rsp_total_held      = total_ext[7:0];

   // checks
   `BQH_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready,
      state_ff != ST_IDLE)
   `BQH_ASSERT_NOW(a_total_bound, clock, reset, 1'b1,
      total_ff <= TW'(MaxCharacters * QueueDepth))
   `BQH_ASSERT_NOW(a_head_check_nonempty, clock, reset, state_ff == ST_EX_HCHK,
      fill_ff != '0)
   `BQH_ASSERT_NEXT(a_emit_loads_output, clock, reset,
      state_ff == ST_EMIT && out_free, rsp_valid && rsp_last_of_run)

endmodule

// File: rtl/core/per_key_bounded_queue_holder.sv
// top level of the per-key bounded queue holder: ttl register, sequencer, stores
// depends on bqh_pkg, bqh_ctrl and bqh_ram
//
// usage:
// req_ channel carries one command beat (push, expire, take). req_ready is high
// only while the block is idle; one command is worked on at a time.
// rsp_ channel returns the result beats of that command; last_of_run marks the
// final one. push, expire and unused codes give one beat; take gives one beat
// per held entry of the key, or one empty beat when the key is absent.
// csr_ channel writes ttl_ticks; it is always ready and meant for idle periods.
// push and take start with a walk over the key slots. a push into a full queue
// then searches its cells and moves the cells above the dropped one down. a
// take gives its entries one beat at a time. an expire walks the slots on its
// own, reading each used slot, dropping expired head entries and moving the
// cells behind them. an unused code goes straight to its result beat. the
// sequencer has one shared age subtract/compare unit and one read and one
// write port per store.
// reset clears the slot valid bits, the held count and the output valid bit and
// loads ttl_ticks with 900. stores need no clearing. a stalled rsp_ready holds
// the output register and the sequencer waits on it.
module per_key_bounded_queue_holder import bqh_pkg::*; #(
   parameter int MaxCharacters = MaxCharactersDefault,
   parameter int QueueDepth    = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_character_id,
   input  logic [31:0] req_payload,
   input  logic        req_completed,
   input  logic [31:0] req_time_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_entry_valid,
   output logic [31:0] rsp_entry_payload,
   output logic        rsp_entry_completed,
   output logic [31:0] rsp_entry_time,
   output logic        rsp_last_of_run,
   output logic [7:0]  rsp_dropped_count,
   output logic        rsp_evicted_count,
   output logic [7:0]  rsp_total_held,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   localparam int SW    = (MaxCharacters > 1) ? $clog2(MaxCharacters) : 1;
   localparam int FW    = $clog2(QueueDepth + 1);
   localparam int Cells = MaxCharacters * QueueDepth;
   localparam int CAW   = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int SLW   = 32 + FW;

   logic [31:0]   ttl_ff, ttl_in;
   logic          slot_wr_en, slot_rd_en, cell_wr_en, cell_rd_en;
   logic [SW-1:0] slot_wr_addr, slot_rd_addr;
   logic [SLW-1:0] slot_wr_data, slot_rd_data;
   logic [CAW-1:0] cell_wr_addr, cell_rd_addr;
   cell_word_type cell_wr_data, cell_rd_data;
   logic [CellWidth-1:0] cell_rd_raw;

   // ttl register
   assign csr_ready = 1'b1;
   assign ttl_in    = (csr_valid && csr_ready) ? csr_wdata : ttl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TtlReset;
      end else begin
         ttl_ff <= ttl_in;
      end
   end

   // sequencer
   bqh_ctrl #(
      .MaxCharacters (MaxCharacters),
      .QueueDepth    (QueueDepth)
   ) u_ctrl (
      .clock, .reset,
      .ttl_ticks (ttl_ff),
      .req_valid, .req_ready, .req_command, .req_character_id, .req_payload,
      .req_completed, .req_time_now,
      .rsp_valid, .rsp_ready, .rsp_entry_valid, .rsp_entry_payload,
      .rsp_entry_completed, .rsp_entry_time, .rsp_last_of_run,
      .rsp_dropped_count, .rsp_evicted_count, .rsp_total_held,
      .slot_wr_en, .slot_wr_addr, .slot_wr_data, .slot_rd_en, .slot_rd_addr,
      .slot_rd_data,
      .cell_wr_en, .cell_wr_addr, .cell_wr_data, .cell_rd_en, .cell_rd_addr,
      .cell_rd_data
   );

   // key and fill store, one word per slot
   bqh_ram #(
      .Width (SLW),
      .Depth (MaxCharacters)
   ) u_slot_ram (
      .clock,
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // entry store, QueueDepth cells per slot
   bqh_ram #(
      .Width (CellWidth),
      .Depth (Cells)
   ) u_cell_ram (
      .clock,
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_en   (cell_rd_en),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_raw)
   );

   assign cell_rd_data = cell_word_type'(cell_rd_raw);

endmodule

// File: bench/per_key_bounded_queue_holder_tb.sv
// self-checking bench for the per-key bounded queue holder
// depends on bqh_pkg and per_key_bounded_queue_holder; predicts every result beat
`timescale 1ns / 1ps

module per_key_bounded_queue_holder_tb;
   import bqh_pkg::*;

   localparam int NumSlots  = 16;
   localparam int Depth     = 8;
   localparam int WatchMax  = 20000;
   localparam int PendSize  = 512;
   localparam int ExpSize   = 64;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] character_id;
      logic [31:0] payload;
      logic        completed;
      logic [31:0] time_now;
   } cmd_beat_type;

   typedef struct packed {
      logic        entry_valid;
      logic [31:0] entry_payload;
      logic        entry_completed;
      logic [31:0] entry_time;
      logic        last_of_run;
      logic [7:0]  dropped_count;
      logic        evicted_count;
      logic [7:0]  total_held;
   } result_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0]  req_command = '0;
   logic [31:0] req_character_id = '0;
   logic [31:0] req_payload = '0;
   logic req_completed = 1'b0;
   logic [31:0] req_time_now = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_entry_valid, rsp_entry_completed, rsp_last_of_run, rsp_evicted_count;
   logic [31:0] rsp_entry_payload, rsp_entry_time;
   logic [7:0]  rsp_dropped_count, rsp_total_held;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [31:0] csr_wdata = '0;

   per_key_bounded_queue_holder dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // mirror of the block state
   logic [31:0] ttl_mirror;
   logic        key_used [NumSlots];
   logic [31:0] key_of [NumSlots];
   int          fill_of [NumSlots];
   logic [31:0] cell_pay [NumSlots][Depth];
   logic        cell_done [NumSlots][Depth];
   logic [31:0] cell_stamp [NumSlots][Depth];

   // pending commands and expected results, ring buffers with running counters
   cmd_beat_type    pend_mem [PendSize];
   int              pend_wr = 0;
   int              pend_rd = 0;
   result_beat_type exp_mem [ExpSize];
   int              exp_wr = 0;
   int              exp_rd = 0;
   int  fail_count = 0;
   int  result_count = 0;
   int  cmds_sent = 0;
   int  take_beats = 0;
   int  idle_cycles = 0;
   bit  sender_hold = 1'b0;

   function automatic void pend_add(cmd_beat_type c);
      pend_mem[pend_wr % PendSize] = c;
      pend_wr++;
   endfunction

   function automatic void exp_add(result_beat_type r);
      exp_mem[exp_wr % ExpSize] = r;
      exp_wr++;
   endfunction

   function automatic logic [7:0] held_total();
      int t = 0;
      for (int s = 0; s < NumSlots; s++) if (key_used[s]) t += fill_of[s];
      return t[7:0];
   endfunction

   function automatic int slot_of_key(logic [31:0] k);
      for (int s = 0; s < NumSlots; s++) if (key_used[s] && key_of[s] == k) return s;
      return -1;
   endfunction

   function automatic void drop_cell(int s, int pos);
      for (int i = pos; i + 1 < fill_of[s]; i++) begin
         cell_pay[s][i]   = cell_pay[s][i+1];
         cell_done[s][i]  = cell_done[s][i+1];
         cell_stamp[s][i] = cell_stamp[s][i+1];
      end
      fill_of[s]--;
   endfunction

   function automatic result_beat_type plain_result(logic [7:0] dr, logic ev);
      result_beat_type r = '0;
      r.last_of_run = 1'b1;
      r.dropped_count = dr;
      r.evicted_count = ev;
      r.total_held = held_total();
      return r;
   endfunction

   // work out the result beats of one accepted command
   function automatic void predict_holder(cmd_beat_type c);
      int s, victim, used;
      logic [31:0] best, age;
      logic [7:0] dropped;
      logic evicted, append;
      result_beat_type r;
      dropped = '0;
      evicted = 1'b0;
      case (c.command)
         CMD_PUSH: begin
            s = slot_of_key(c.character_id);
            if (s < 0) begin
               used = 0; victim = -1; best = '0;
               for (int i = 0; i < NumSlots; i++) begin
                  if (!key_used[i]) continue;
                  used++;
                  age = c.time_now - cell_stamp[i][0];
                  if (victim < 0 || age > best) begin
                     best = age; victim = i;
                  end
               end
               if (used >= NumSlots) begin
                  key_used[victim] = 1'b0;
                  fill_of[victim] = 0;
                  evicted = 1'b1;
               end
               for (int i = NumSlots - 1; i >= 0; i--) if (!key_used[i]) s = i;
               key_used[s] = 1'b1;
               key_of[s] = c.character_id;
               fill_of[s] = 0;
            end
            append = 1'b1;
            if (fill_of[s] >= Depth) begin
               victim = -1;
               for (int i = Depth - 1; i >= 0; i--) if (!cell_done[s][i]) victim = i;
               dropped = 8'd1;
               if (victim >= 0) drop_cell(s, victim);
               else if (!c.completed) append = 1'b0;
               else drop_cell(s, 0);
            end
            if (append) begin
               cell_pay[s][fill_of[s]]   = c.payload;
               cell_done[s][fill_of[s]]  = c.completed;
               cell_stamp[s][fill_of[s]] = c.time_now;
               fill_of[s]++;
            end
            exp_add(plain_result(dropped, evicted));
         end
         CMD_EXPIRE: begin
            for (int i = 0; i < NumSlots; i++) begin
               if (!key_used[i]) continue;
               while (fill_of[i] > 0 && (c.time_now - cell_stamp[i][0]) >= ttl_mirror) begin
                  drop_cell(i, 0);
                  dropped++;
               end
               if (fill_of[i] == 0) key_used[i] = 1'b0;
            end
            exp_add(plain_result(dropped, 1'b0));
         end
         CMD_TAKE: begin
            s = slot_of_key(c.character_id);
            if (s < 0) begin
               exp_add(plain_result('0, 1'b0));
            end else begin
               key_used[s] = 1'b0;
               for (int i = 0; i < fill_of[s]; i++) begin
                  r = '0;
                  r.entry_valid = 1'b1;
                  r.entry_payload = cell_pay[s][i];
                  r.entry_completed = cell_done[s][i];
                  r.entry_time = cell_stamp[s][i];
                  r.last_of_run = (i + 1 == fill_of[s]);
                  r.total_held = held_total();
                  exp_add(r);
               end
               fill_of[s] = 0;
            end
         end
         default: exp_add(plain_result('0, 1'b0));
      endcase
   endfunction

   function automatic int gap_length();
      int p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // command driver
   int send_gap = 0;
   bit req_taken;
   always @(posedge clock) req_taken <= req_valid && req_ready && !reset;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold until accepted
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (!sender_hold && (pend_wr - pend_rd) > 0) begin
         cmd_beat_type c;
         c = pend_mem[pend_rd % PendSize];
         pend_rd++;
         req_valid <= 1'b1;
         req_command <= c.command;
         req_character_id <= c.character_id;
         req_payload <= c.payload;
         req_completed <= c.completed;
         req_time_now <= c.time_now;
         send_gap <= gap_length();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result ready with random stalls
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= gap_length();
      end
   end

   // monitor: predict on accepted commands, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_valid && req_ready) begin
            predict_holder(cmd_beat_type'({cmd_type'(req_command), req_character_id,
                                          req_payload, req_completed, req_time_now}));
            cmds_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (rsp_entry_valid) take_beats++;
            if (exp_wr == exp_rd) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               result_beat_type e;
               e = exp_mem[exp_rd % ExpSize];
               exp_rd++;
               if (rsp_entry_valid !== e.entry_valid) begin
                  $error("entry_valid exp %0h got %0h", e.entry_valid, rsp_entry_valid);
                  fail_count++;
               end
               if (rsp_entry_payload !== e.entry_payload) begin
                  $error("entry_payload exp %0h got %0h", e.entry_payload, rsp_entry_payload);
                  fail_count++;
               end
               if (rsp_entry_completed !== e.entry_completed) begin
                  $error("entry_completed exp %0h got %0h", e.entry_completed,
                         rsp_entry_completed);
                  fail_count++;
               end
               if (rsp_entry_time !== e.entry_time) begin
                  $error("entry_time exp %0h got %0h", e.entry_time, rsp_entry_time);
                  fail_count++;
               end
               if (rsp_last_of_run !== e.last_of_run) begin
                  $error("last_of_run exp %0h got %0h", e.last_of_run, rsp_last_of_run);
                  fail_count++;
               end
               if (rsp_dropped_count !== e.dropped_count) begin
                  $error("dropped_count exp %0d got %0d", e.dropped_count, rsp_dropped_count);
                  fail_count++;
               end
               if (rsp_evicted_count !== e.evicted_count) begin
                  $error("evicted_count exp %0h got %0h", e.evicted_count, rsp_evicted_count);
                  fail_count++;
               end
               if (rsp_total_held !== e.total_held) begin
                  $error("total_held exp %0d got %0d", e.total_held, rsp_total_held);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (idle_cycles >= WatchMax) begin
         $display("watchdog expired, %0d results still expected", exp_wr - exp_rd);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic cmd_beat_type make_cmd(cmd_type op, logic [31:0] k, logic [31:0] p,
                                             logic d, logic [31:0] t);
      return '{command: op, character_id: k, payload: p, completed: d, time_now: t};
   endfunction

   task automatic wait_drained();
      while ((pend_wr - pend_rd) > 0 || req_valid || exp_wr != exp_rd)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_ttl(logic [31:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ttl_mirror = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // key pool kept small so queues fill and the table overflows
   logic [31:0] key_pool [20];
   logic [31:0] clk_ticks;

   task automatic add_random(int count);
      int p;
      logic [31:0] k;
      for (int n = 0; n < count; n++) begin
         clk_ticks += $urandom_range(0, 120);
         p = $urandom_range(0, 99);
         k = key_pool[$urandom_range(0, 19)];
         if (p < 60)
            pend_add(make_cmd(CMD_PUSH, k, $urandom, 1'($urandom_range(0, 1)),
                              ($urandom_range(0, 9) == 0) ? $urandom : clk_ticks));
         else if (p < 75)
            pend_add(make_cmd(CMD_EXPIRE, $urandom, $urandom, 1'($urandom_range(0, 1)),
                              clk_ticks));
         else if (p < 96)
            pend_add(make_cmd(CMD_TAKE, ($urandom_range(0, 5) == 0) ? $urandom : k,
                              $urandom, 1'($urandom_range(0, 1)), clk_ticks));
         else
            pend_add(make_cmd(CMD_NONE, $urandom, $urandom, 1'($urandom_range(0, 1)),
                              $urandom));
      end
   endtask

   initial begin
      ttl_mirror = TtlReset;
      for (int s = 0; s < NumSlots; s++) begin
         key_used[s] = 1'b0;
         fill_of[s] = 0;
         key_of[s] = '0;
      end
      for (int i = 0; i < 20; i++) key_pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom;
      key_pool[1] = '0;
      clk_ticks = 32'd1000;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, overflow, all-completed queue, absent take, unused code
      pend_add(make_cmd(CMD_TAKE, 32'h1234, '0, 1'b0, '0));
      pend_add(make_cmd(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
      for (int i = 0; i < 8; i++)
         pend_add(make_cmd(CMD_PUSH, '0, 32'hA000_0000 + i, 1'b1, 100 + i));
      pend_add(make_cmd(CMD_PUSH, '0, 32'hFFFF_FFFF, 1'b0, 200));
      pend_add(make_cmd(CMD_PUSH, '0, 32'h5555_5555, 1'b1, 201));
      pend_add(make_cmd(CMD_PUSH, 32'hFFFF_FFFF, '0, 1'b0, 32'hFFFF_FFFF));
      pend_add(make_cmd(CMD_EXPIRE, '0, '0, 1'b0, 32'd300));
      pend_add(make_cmd(CMD_TAKE, '0, '0, 1'b0, '0));
      pend_add(make_cmd(CMD_EXPIRE, '0, '0, 1'b0, 32'd2000));
      pend_add(make_cmd(CMD_TAKE, 32'hFFFF_FFFF, '0, 1'b0, '0));
      wait_drained();

      // fill the key table then push one new key to force an eviction
      for (int i = 0; i < 17; i++)
         pend_add(make_cmd(CMD_PUSH, 32'h100 + i, i, i[0], 5000 - i));
      wait_drained();

      // zero ttl drops everything
      write_ttl(32'd0);
      pend_add(make_cmd(CMD_EXPIRE, '0, '0, 1'b0, 32'd6000));
      wait_drained();

      // random phases across ttl settings, one with the sender held mid-phase until drained
      write_ttl(32'hFFFF_FFFF);
      add_random(60);
      wait_drained();
      write_ttl(32'd300);
      add_random(80);
      wait ((pend_wr - pend_rd) <= 40);
      sender_hold = 1'b1;
      wait (exp_wr == exp_rd && !req_valid);
      sender_hold = 1'b0;
      wait_drained();
      write_ttl($urandom_range(50, 2000));
      add_random(110);
      wait_drained();

      $display("covered %0d commands, %0d result beats, %0d of them taken entries",
               cmds_sent, result_count, take_beats);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
